@@ sv/matcs_pkg.sv @@
// ----------------------------------------------------------------------------
// matcs_pkg
// Shared codes and types for the motor axis task chain sequencer.
// ----------------------------------------------------------------------------
package matcs_pkg;

  // Axis state codes
  localparam int unsigned CODE_W = 4;
  typedef logic [CODE_W-1:0] code_t;

  localparam code_t ST_UNDEF     = 4'd0;
  localparam code_t ST_IDLE      = 4'd1;
  localparam code_t ST_STARTUP   = 4'd2;
  localparam code_t ST_FULLCAL   = 4'd3;
  localparam code_t ST_MOTORCAL  = 4'd4;
  localparam code_t ST_INDEX     = 4'd6;
  localparam code_t ST_OFFSET    = 4'd7;
  localparam code_t ST_CLOSED    = 4'd8;
  localparam code_t ST_LOCKIN    = 4'd9;
  localparam code_t ST_DIRFIND   = 4'd10;
  localparam code_t ST_HOMING    = 4'd11;
  localparam code_t ST_HALLPOL   = 4'd12;
  localparam code_t ST_HALLPHASE = 4'd13;

  // Input word actions
  localparam logic ACT_REQUEST = 1'b0;
  localparam logic ACT_DONE    = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 5;
  localparam logic [CFG_IDX_W-1:0] REG_STARTUP_MASK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_USES_INDEX   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IS_HALL      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SENSORLESS   = 2'd3;

  // Startup mask bits
  localparam int unsigned MASK_MOTORCAL = 0;
  localparam int unsigned MASK_INDEX    = 1;
  localparam int unsigned MASK_OFFSET   = 2;
  localparam int unsigned MASK_HOMING   = 3;
  localparam int unsigned MASK_CLOSED   = 4;

  // Longest chain a request can build (startup with all steps, then idle)
  localparam int unsigned BUILD_SLOTS = 6;

  // Count output width
  localparam int unsigned TASKS_W = 4;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] startup_mask;
    logic                  uses_index;
    logic                  is_hall;
    logic                  sensorless;
  } cfg_t;

  typedef struct packed {
    logic ok;
    logic hall_pulse;
  } check_t;

endpackage

@@ sv/matcs_chain_build.sv @@
// ----------------------------------------------------------------------------
// matcs_chain_build
// Expands a state request into a task chain and its length.
// ----------------------------------------------------------------------------
module matcs_chain_build
  import matcs_pkg::*;
#(
  parameter int unsigned DEPTH = 8
) (
  input  code_t                          req_code,
  input  cfg_t                           cfg,
  output code_t                          chain_o [DEPTH],
  output logic [$clog2(DEPTH+1)-1:0]     count_o
);

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH+1);

  code_t                  cand_code [BUILD_SLOTS];
  logic [BUILD_SLOTS-1:0] cand_en;
  logic [CNT_W-1:0]       pos;

  // Candidate steps in chain order, each with its enable
  always_comb begin
    for (int k = 0; k < BUILD_SLOTS; k++) begin
      cand_code[k] = ST_UNDEF;
    end
    cand_en = '0;
    case (req_code)
      ST_STARTUP: begin
        cand_code[0] = ST_MOTORCAL;
        cand_en[0]   = cfg.startup_mask[MASK_MOTORCAL];
        cand_code[1] = ST_INDEX;
        cand_en[1]   = cfg.startup_mask[MASK_INDEX] & cfg.uses_index;
        cand_code[2] = ST_OFFSET;
        cand_en[2]   = cfg.startup_mask[MASK_OFFSET];
        cand_code[3] = ST_HOMING;
        cand_en[3]   = cfg.startup_mask[MASK_HOMING];
        cand_code[4] = ST_CLOSED;
        cand_en[4]   = cfg.startup_mask[MASK_CLOSED];
        cand_code[5] = ST_IDLE;
        cand_en[5]   = 1'b1;
      end
      ST_FULLCAL: begin
        cand_code[0] = ST_MOTORCAL;
        cand_en[0]   = 1'b1;
        cand_code[1] = ST_HALLPOL;
        cand_en[1]   = cfg.is_hall;
        cand_code[2] = ST_INDEX;
        cand_en[2]   = cfg.uses_index;
        cand_code[3] = ST_OFFSET;
        cand_en[3]   = 1'b1;
        cand_code[4] = ST_IDLE;
        cand_en[4]   = 1'b1;
      end
      default: begin
        cand_code[0] = req_code;
        cand_en[0]   = 1'b1;
        cand_code[1] = ST_IDLE;
        cand_en[1]   = 1'b1;
      end
    endcase
  end

  // Pack enabled steps to the front; excess past the depth is dropped
  always_comb begin
    for (int j = 0; j < DEPTH; j++) begin
      chain_o[j] = ST_UNDEF;
    end
    pos = '0;
    for (int k = 0; k < BUILD_SLOTS; k++) begin
      if (cand_en[k] && (pos < CNT_W'(DEPTH))) begin
        chain_o[pos[IDX_W-1:0]] = cand_code[k];
        pos = pos + 1'b1;
      end
    end
  end

  assign count_o = pos;

endmodule

@@ sv/matcs_head_check.sv @@
// ----------------------------------------------------------------------------
// matcs_head_check
// Prerequisite check for a new head of the task chain.
// ----------------------------------------------------------------------------
module matcs_head_check
  import matcs_pkg::*;
(
  input  code_t  head,
  input  logic   motor_calibrated,
  input  logic   direction_known,
  input  logic   hall_polarity_done,
  input  logic   sensorless,
  output check_t chk
);

  always_comb begin
    chk = '0;
    case (head)
      ST_IDLE, ST_MOTORCAL, ST_HOMING: begin
        chk.ok = 1'b1;
      end
      ST_INDEX, ST_DIRFIND, ST_HALLPOL, ST_OFFSET: begin
        chk.ok = motor_calibrated;
      end
      ST_HALLPHASE: begin
        // pulse only when motor is calibrated but polarity is missing
        chk.ok         = motor_calibrated & hall_polarity_done;
        chk.hall_pulse = motor_calibrated & ~hall_polarity_done;
      end
      ST_LOCKIN: begin
        chk.ok = motor_calibrated & direction_known;
      end
      ST_CLOSED: begin
        chk.ok = motor_calibrated & (direction_known | sensorless);
      end
      default: begin
        // undefined and unhandled codes always fail
        chk.ok = 1'b0;
      end
    endcase
  end

endmodule

@@ sv/motor_axis_task_chain_sequencer.sv @@
// ----------------------------------------------------------------------------
// motor_axis_task_chain_sequencer
// Keeps the axis task chain, applies request and completion words, checks
// each new head and returns the head, error flag and chain length.
//
//   channel | direction | handshake         | word
//   --------+-----------+-------------------+-------------------------------
//   in_     | input     | in_valid/in_ready | action, request, prereq flags
//   out_    | output    | out_valid/ready   | head, error, hall pulse, count
//   cfg_    | input     | cfg_we            | index + data, no read-back
//
// One word per cycle unless stalled; each result is registered when taken.
// The chain and result registers update together in a single pass.
// in_ready is high whenever the result register is empty or being drained.
// Reset empties the chain, clears the error flag and the config registers.
// ----------------------------------------------------------------------------
module motor_axis_task_chain_sequencer
  import matcs_pkg::*;
#(
  parameter int unsigned CHAIN_DEPTH = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_action,
  input  logic [3:0]            in_requested_state,
  input  logic                  in_task_ok,
  input  logic                  in_motor_calibrated,
  input  logic                  in_direction_known,
  input  logic                  in_hall_polarity_done,

  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [3:0]            out_run_state,
  output logic                  out_invalid_state_error,
  output logic                  out_hall_not_calibrated,
  output logic [3:0]            out_tasks_remaining,

  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int unsigned CNT_W = $clog2(CHAIN_DEPTH+1);

  cfg_t             cfg_r;
  code_t            chain_r   [CHAIN_DEPTH];
  code_t            chain_nxt [CHAIN_DEPTH];
  code_t            build_chain [CHAIN_DEPTH];
  logic [CNT_W-1:0] build_cnt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             flag_r, flag_nxt;
  logic             pulse_nxt;
  logic             out_valid_r;
  code_t            out_run_state_r;
  logic             out_err_r;
  logic             out_hall_r;
  logic [3:0]       out_tasks_r;

  logic             in_acc;
  logic             req_evt;
  logic             advance;
  logic             new_head;
  code_t            head_code;
  check_t           chk;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_STARTUP_MASK: cfg_r.startup_mask <= cfg_wdata;
        REG_USES_INDEX:   cfg_r.uses_index   <= cfg_wdata[0];
        REG_IS_HALL:      cfg_r.is_hall      <= cfg_wdata[0];
        REG_SENSORLESS:   cfg_r.sensorless   <= cfg_wdata[0];
        default:          cfg_r <= cfg_r;
      endcase
    end
  end

  // Handshake
  assign in_ready = !out_valid_r || out_ready;
  assign in_acc   = in_valid && in_ready;

  // Chain built from a request
  matcs_chain_build #(
    .DEPTH (CHAIN_DEPTH)
  ) u_build (
    .req_code (in_requested_state),
    .cfg      (cfg_r),
    .chain_o  (build_chain),
    .count_o  (build_cnt)
  );

  // Event decode; idle that completes counts as a success
  assign req_evt   = (in_action == ACT_REQUEST) && (in_requested_state != ST_UNDEF);
  assign advance   = in_task_ok || (chain_r[0] == ST_IDLE);
  assign new_head  = req_evt || ((in_action == ACT_DONE) && advance);
  assign head_code = req_evt ? build_chain[0] : chain_r[1];

  matcs_head_check u_check (
    .head               (head_code),
    .motor_calibrated   (in_motor_calibrated),
    .direction_known    (in_direction_known),
    .hall_polarity_done (in_hall_polarity_done),
    .sensorless         (cfg_r.sensorless),
    .chk                (chk)
  );

  // Next chain, count and flag
  always_comb begin
    chain_nxt = chain_r;
    cnt_nxt   = cnt_r;
    flag_nxt  = flag_r;
    pulse_nxt = new_head && chk.hall_pulse;
    if (in_action == ACT_REQUEST) begin
      if (req_evt) begin
        chain_nxt = build_chain;
        cnt_nxt   = build_cnt;
        flag_nxt  = 1'b0;
      end
    end else if (advance) begin
      for (int i = 0; i < CHAIN_DEPTH - 1; i++) begin
        chain_nxt[i] = chain_r[i+1];
      end
      chain_nxt[CHAIN_DEPTH-1] = ST_UNDEF;
      cnt_nxt = (cnt_r != '0) ? cnt_r - 1'b1 : '0;
    end else begin
      // failed task: idle alone
      for (int i = 0; i < CHAIN_DEPTH; i++) begin
        chain_nxt[i] = ST_UNDEF;
      end
      chain_nxt[0] = ST_IDLE;
      cnt_nxt      = CNT_W'(1);
    end
    // failed prerequisite check: error and idle alone
    if (new_head && !chk.ok) begin
      for (int i = 0; i < CHAIN_DEPTH; i++) begin
        chain_nxt[i] = ST_UNDEF;
      end
      chain_nxt[0] = ST_IDLE;
      cnt_nxt      = CNT_W'(1);
      flag_nxt     = 1'b1;
    end
  end

  // Chain state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHAIN_DEPTH; i++) begin
        chain_r[i] <= ST_UNDEF;
      end
      cnt_r  <= '0;
      flag_r <= 1'b0;
    end else if (in_acc) begin
      chain_r <= chain_nxt;
      cnt_r   <= cnt_nxt;
      flag_r  <= flag_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_run_state_r <= chain_nxt[0];
      out_err_r       <= flag_nxt;
      out_hall_r      <= pulse_nxt;
      out_tasks_r     <= TASKS_W'(cnt_nxt);
    end
  end

  assign out_valid               = out_valid_r;
  assign out_run_state           = out_run_state_r;
  assign out_invalid_state_error = out_err_r;
  assign out_hall_not_calibrated = out_hall_r;
  assign out_tasks_remaining     = out_tasks_r;

endmodule

@@ sv/matcs_checker.sv @@
// ----------------------------------------------------------------------------
// matcs_checker
// Port-level assertions for the task chain sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module matcs_checker
  import matcs_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [3:0]            out_run_state,
  input logic                  out_invalid_state_error,
  input logic                  out_hall_not_calibrated,
  input logic [3:0]            out_tasks_remaining
);

  // Stalled result holds its word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_run_state)
      && $stable(out_tasks_remaining) && $stable(out_invalid_state_error))
    else $error("result changed while stalled");

  // Every accepted word gives a result on the next cycle
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted word gave no result");

  // Error flag means the chain was dropped to idle alone
  a_err_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_invalid_state_error |->
      out_run_state == ST_IDLE && out_tasks_remaining == 4'd1)
    else $error("error set but chain not idle");

  // Hall pulse only comes with a refused head
  a_hall_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hall_not_calibrated |->
      out_invalid_state_error && out_run_state == ST_IDLE)
    else $error("hall pulse without refusal");

  // A defined head is always counted
  a_head_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_run_state != ST_UNDEF |-> out_tasks_remaining != 4'd0)
    else $error("defined head with zero count");

endmodule

bind motor_axis_task_chain_sequencer matcs_checker u_matcs_checker (.*);

@@ tb/tb_motor_axis_task_chain_sequencer.sv @@
// ----------------------------------------------------------------------------
// tb_motor_axis_task_chain_sequencer
// Self-checking bench for the axis task chain sequencer. A directed table
// covers empty chains, codes with no handler, refused heads and the hall pulse.
// Random phases under different register settings then run mostly well-formed
// request and completion sequences. Each result word is checked against a typed
// entry or an in-bench chain model, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_motor_axis_task_chain_sequencer;
  import matcs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH           = 8;
  localparam int unsigned NUM_PHASES      = 8;
  localparam int unsigned WORDS_PER_PHASE = 128;
  localparam int unsigned CYCLE_LIMIT     = 200000;
  localparam int unsigned MAX_REPORTS     = 10;

  typedef struct packed {
    logic  action;
    code_t req;
    logic  ok;
    logic  mcal;
    logic  dir;
    logic  hpol;
  } axis_word_t;

  typedef struct packed {
    code_t              head;
    logic               err;
    logic               hall_pulse;
    logic [TASKS_W-1:0] count;
  } head_report_t;

  typedef enum logic [1:0] {ROW_PRED, ROW_TYPED, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e    kind;
    cfg_t         cfg;
    axis_word_t   w;
    head_report_t exp;
  } plan_row_t;

  // DUT connections, all inputs known from time zero
  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_action = ACT_REQUEST;
  logic [3:0]            in_requested_state = ST_UNDEF;
  logic                  in_task_ok = 1'b0;
  logic                  in_motor_calibrated = 1'b0;
  logic                  in_direction_known = 1'b0;
  logic                  in_hall_polarity_done = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [3:0]            out_run_state;
  logic                  out_invalid_state_error;
  logic                  out_hall_not_calibrated;
  logic [3:0]            out_tasks_remaining;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_STARTUP_MASK;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Model state
  code_t        chain_model [DEPTH];
  logic         err_model;
  cfg_t         cfg_model;
  head_report_t expected_heads [$];
  plan_row_t    plan [$];

  logic         steady = 1'b0;
  int unsigned  cycle_count = 0;
  int unsigned  mismatches = 0;
  int unsigned  results_seen = 0;
  int unsigned  requests_sent = 0;
  int unsigned  completions_sent = 0;
  int unsigned  heads_refused = 0;
  int unsigned  settings_used = 0;

  motor_axis_task_chain_sequencer #(
    .CHAIN_DEPTH(DEPTH)
  ) dut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_ready                (in_ready),
    .in_action               (in_action),
    .in_requested_state      (in_requested_state),
    .in_task_ok              (in_task_ok),
    .in_motor_calibrated     (in_motor_calibrated),
    .in_direction_known      (in_direction_known),
    .in_hall_polarity_done   (in_hall_polarity_done),
    .out_valid               (out_valid),
    .out_ready               (out_ready),
    .out_run_state           (out_run_state),
    .out_invalid_state_error (out_invalid_state_error),
    .out_hall_not_calibrated (out_hall_not_calibrated),
    .out_tasks_remaining     (out_tasks_remaining),
    .cfg_we                  (cfg_we),
    .cfg_index               (cfg_index),
    .cfg_wdata               (cfg_wdata)
  );

  always #10 clk = ~clk;

  // Chain collapses to a lone idle entry
  function automatic void chain_to_idle();
    for (int i = 0; i < DEPTH; i++) chain_model[i] = ST_UNDEF;
    chain_model[0] = ST_IDLE;
  endfunction

  // Apply one accepted word to the model chain and return the head report
  function automatic head_report_t advance_chain(input axis_word_t w);
    code_t        steps [$];
    logic         fresh_head;
    logic         allowed;
    int unsigned  n;
    head_report_t r;
    r = '0;
    fresh_head = 1'b0;
    allowed = 1'b1;
    if (w.action == ACT_REQUEST) begin
      if (w.req != ST_UNDEF) begin
        if (w.req == ST_STARTUP) begin
          if (cfg_model.startup_mask[MASK_MOTORCAL]) steps.push_back(ST_MOTORCAL);
          if (cfg_model.startup_mask[MASK_INDEX] && cfg_model.uses_index)
            steps.push_back(ST_INDEX);
          if (cfg_model.startup_mask[MASK_OFFSET]) steps.push_back(ST_OFFSET);
          if (cfg_model.startup_mask[MASK_HOMING]) steps.push_back(ST_HOMING);
          if (cfg_model.startup_mask[MASK_CLOSED]) steps.push_back(ST_CLOSED);
        end else if (w.req == ST_FULLCAL) begin
          steps.push_back(ST_MOTORCAL);
          if (cfg_model.is_hall) steps.push_back(ST_HALLPOL);
          if (cfg_model.uses_index) steps.push_back(ST_INDEX);
          steps.push_back(ST_OFFSET);
        end else begin
          steps.push_back(w.req);
        end
        steps.push_back(ST_IDLE);
        // entries past the chain depth are dropped
        for (int i = 0; i < DEPTH; i++)
          chain_model[i] = (i < steps.size()) ? steps[i] : ST_UNDEF;
        err_model = 1'b0;
        fresh_head = 1'b1;
      end
    end else if (w.ok || chain_model[0] == ST_IDLE) begin
      // completed idle counts as success regardless of ok
      for (int i = 0; i < DEPTH - 1; i++) chain_model[i] = chain_model[i+1];
      chain_model[DEPTH-1] = ST_UNDEF;
      fresh_head = 1'b1;
    end else begin
      chain_to_idle();
    end

    // prerequisite check on a new head
    if (fresh_head) begin
      case (chain_model[0])
        ST_IDLE, ST_MOTORCAL, ST_HOMING: allowed = 1'b1;
        ST_INDEX, ST_DIRFIND, ST_HALLPOL, ST_OFFSET: allowed = w.mcal;
        ST_HALLPHASE: begin
          allowed = w.mcal && w.hpol;
          r.hall_pulse = w.mcal && !w.hpol;
        end
        ST_LOCKIN: allowed = w.mcal && w.dir;
        ST_CLOSED: allowed = w.mcal && (w.dir || cfg_model.sensorless);
        default: allowed = 1'b0;
      endcase
      if (!allowed) begin
        err_model = 1'b1;
        chain_to_idle();
        heads_refused++;
      end
    end

    n = 0;
    for (int i = 0; i < DEPTH; i++) begin
      if (chain_model[i] == ST_UNDEF) break;
      n++;
    end
    r.head  = chain_model[0];
    r.err   = err_model;
    r.count = TASKS_W'(n);
    return r;
  endfunction

  function automatic axis_word_t mk_word(input logic a, input code_t req,
                                         input logic ok, m, d, h);
    axis_word_t w;
    w.action = a;
    w.req    = req;
    w.ok     = ok;
    w.mcal   = m;
    w.dir    = d;
    w.hpol   = h;
    return w;
  endfunction

  function automatic plan_row_t pred_row(input logic a, input code_t req,
                                         input logic ok, m, d, h);
    plan_row_t row;
    row      = '0;
    row.kind = ROW_PRED;
    row.w    = mk_word(a, req, ok, m, d, h);
    return row;
  endfunction

  function automatic plan_row_t typed_row(input logic a, input code_t req,
                                          input logic ok, m, d, h,
                                          input code_t head, input logic err, pulse,
                                          input int unsigned cnt);
    plan_row_t row;
    row                = pred_row(a, req, ok, m, d, h);
    row.kind           = ROW_TYPED;
    row.exp.head       = head;
    row.exp.err        = err;
    row.exp.hall_pulse = pulse;
    row.exp.count      = TASKS_W'(cnt);
    return row;
  endfunction

  function automatic plan_row_t cfg_row(input cfg_t c);
    plan_row_t row;
    row      = '0;
    row.kind = ROW_CFG;
    row.cfg  = c;
    return row;
  endfunction

  // Random word: mostly successful completions; requests favour startup and full-cal
  function automatic axis_word_t random_word();
    axis_word_t  w;
    int unsigned pick;
    w.action = ($urandom_range(99) < 35) ? ACT_REQUEST : ACT_DONE;
    pick     = $urandom_range(99);
    if (w.action == ACT_REQUEST && pick < 25)      w.req = ST_STARTUP;
    else if (w.action == ACT_REQUEST && pick < 45) w.req = ST_FULLCAL;
    else                                           w.req = code_t'($urandom_range(15));
    w.ok   = ($urandom_range(99) < 85);
    w.mcal = ($urandom_range(99) < 85);
    w.dir  = ($urandom_range(99) < 70);
    w.hpol = ($urandom_range(99) < 80);
    return w;
  endfunction

  // Present one word, hold until taken, then queue its expected report
  task automatic send_word(input axis_word_t w, input logic typed,
                           input head_report_t typed_exp);
    int unsigned  gap;
    head_report_t r;
    gap = 0;
    if (!steady) while ($urandom_range(99) < 33) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid              <= 1'b1;
    in_action             <= w.action;
    in_requested_state    <= w.req;
    in_task_ok            <= w.ok;
    in_motor_calibrated   <= w.mcal;
    in_direction_known    <= w.dir;
    in_hall_polarity_done <= w.hpol;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = advance_chain(w);
    expected_heads.push_back(typed ? typed_exp : r);
    if (w.action == ACT_REQUEST) requests_sent++;
    else                         completions_sent++;
  endtask

  // Stop sending and wait for every outstanding report
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_heads.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Write all four registers, one per cycle
  task automatic program_cfg(input cfg_t c);
    cfg_we    <= 1'b1;
    cfg_index <= REG_STARTUP_MASK;
    cfg_wdata <= c.startup_mask;
    @(posedge clk);
    cfg_index <= REG_USES_INDEX;
    cfg_wdata <= CFG_DATA_W'(c.uses_index);
    @(posedge clk);
    cfg_index <= REG_IS_HALL;
    cfg_wdata <= CFG_DATA_W'(c.is_hall);
    @(posedge clk);
    cfg_index <= REG_SENSORLESS;
    cfg_wdata <= CFG_DATA_W'(c.sensorless);
    @(posedge clk);
    cfg_we    <= 1'b0;
    cfg_model = c;
    settings_used++;
  endtask

  // Receiver back-pressure
  always @(posedge clk) begin
    out_ready <= steady ? 1'b1 : ($urandom_range(99) >= 33);
  end

  // Result checker
  always @(posedge clk) begin
    head_report_t exp;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (expected_heads.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("ERROR: unexpected result word head=%0d err=%0b pulse=%0b count=%0d",
                   out_run_state, out_invalid_state_error,
                   out_hall_not_calibrated, out_tasks_remaining);
      end else begin
        exp = expected_heads.pop_front();
        if (out_run_state !== exp.head || out_invalid_state_error !== exp.err ||
            out_hall_not_calibrated !== exp.hall_pulse ||
            out_tasks_remaining !== exp.count) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display({"ERROR: result %0d: exp head=%0d err=%0b pulse=%0b count=%0d,",
                      " got head=%0d err=%0b pulse=%0b count=%0d"},
                     results_seen, exp.head, exp.err, exp.hall_pulse, exp.count,
                     out_run_state, out_invalid_state_error,
                     out_hall_not_calibrated, out_tasks_remaining);
        end
      end
    end
  end

  // Timeout guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_heads.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    cfg_t c;
    for (int i = 0; i < DEPTH; i++) chain_model[i] = ST_UNDEF;
    err_model = 1'b0;
    cfg_model = '0;

    // Directed table, registers at reset values first
    plan.push_back(typed_row(ACT_REQUEST, ST_UNDEF, 0, 0, 0, 0, ST_UNDEF, 0, 0, 0));
    plan.push_back(typed_row(ACT_DONE, ST_UNDEF, 1, 0, 0, 0, ST_IDLE, 1, 0, 1));
    plan.push_back(typed_row(ACT_REQUEST, ST_IDLE, 0, 0, 0, 0, ST_IDLE, 0, 0, 2));
    plan.push_back(pred_row(ACT_DONE, ST_UNDEF, 0, 0, 0, 0));
    plan.push_back(typed_row(ACT_DONE, 4'd15, 0, 1, 1, 1, ST_IDLE, 1, 0, 1));
    plan.push_back(typed_row(ACT_REQUEST, 4'd5, 1, 1, 1, 1, ST_IDLE, 1, 0, 1));
    plan.push_back(typed_row(ACT_REQUEST, 4'd14, 1, 1, 1, 1, ST_IDLE, 1, 0, 1));
    plan.push_back(typed_row(ACT_REQUEST, ST_HALLPHASE, 1, 1, 1, 0, ST_IDLE, 1, 1, 1));
    plan.push_back(pred_row(ACT_REQUEST, ST_HALLPHASE, 1, 1, 0, 1));
    plan.push_back(pred_row(ACT_DONE, ST_UNDEF, 0, 1, 1, 1));
    plan.push_back(pred_row(ACT_REQUEST, ST_CLOSED, 1, 1, 0, 1));
    plan.push_back(pred_row(ACT_REQUEST, ST_LOCKIN, 1, 1, 1, 1));
    plan.push_back(pred_row(ACT_REQUEST, ST_DIRFIND, 1, 0, 1, 1));
    plan.push_back(pred_row(ACT_REQUEST, ST_FULLCAL, 1, 1, 1, 1));
    plan.push_back(pred_row(ACT_DONE, ST_UNDEF, 1, 1, 1, 1));
    plan.push_back(pred_row(ACT_DONE, ST_UNDEF, 1, 1, 1, 1));
    plan.push_back(pred_row(ACT_DONE, ST_UNDEF, 1, 1, 1, 1));
    plan.push_back(pred_row(ACT_REQUEST, ST_STARTUP, 0, 0, 0, 0));
    c.startup_mask = '1;
    c.uses_index   = 1'b1;
    c.is_hall      = 1'b1;
    c.sensorless   = 1'b1;
    plan.push_back(cfg_row(c));
    // full startup chain, closed loop reached without direction (sensorless)
    plan.push_back(pred_row(ACT_REQUEST, ST_STARTUP, 1, 1, 0, 0));
    plan.push_back(pred_row(ACT_DONE, ST_UNDEF, 1, 1, 0, 0));
    plan.push_back(pred_row(ACT_DONE, ST_UNDEF, 1, 1, 0, 0));
    plan.push_back(pred_row(ACT_DONE, ST_UNDEF, 1, 1, 0, 0));
    plan.push_back(pred_row(ACT_DONE, ST_UNDEF, 1, 1, 0, 0));
    plan.push_back(pred_row(ACT_REQUEST, ST_FULLCAL, 1, 1, 1, 0));
    plan.push_back(pred_row(ACT_REQUEST, ST_OFFSET, 1, 0, 1, 1));
    plan.push_back(pred_row(ACT_REQUEST, ST_INDEX, 1, 1, 1, 1));

    // Reset
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    settings_used = 1;

    foreach (plan[i]) begin
      case (plan[i].kind)
        ROW_CFG: begin
          settle();
          program_cfg(plan[i].cfg);
        end
        ROW_TYPED: send_word(plan[i].w, 1'b1, plan[i].exp);
        default:   send_word(plan[i].w, 1'b0, '0);
      endcase
    end

    // Random phases; each starts with a full drain before the register writes
    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      if (p == 0) begin
        c = '0;
      end else if (p == 1) begin
        c.startup_mask = '1;
        c.uses_index   = 1'b1;
        c.is_hall      = 1'b1;
        c.sensorless   = 1'b1;
      end else begin
        c.startup_mask = CFG_DATA_W'($urandom_range(31));
        c.uses_index   = 1'($urandom_range(1));
        c.is_hall      = 1'($urandom_range(1));
        c.sensorless   = 1'($urandom_range(1));
      end
      program_cfg(c);
      steady = (p == 3);
      repeat (WORDS_PER_PHASE) send_word(random_word(), 1'b0, '0);
      steady = 1'b0;
    end

    settle();
    repeat (5) @(posedge clk);
    mismatches += expected_heads.size();

    $display("Covered %0d request words and %0d completion words over %0d register settings.",
             requests_sent, completions_sent, settings_used);
    $display("Checked %0d result words; %0d new heads refused by prerequisite checks.",
             results_seen, heads_refused);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
